@@ hdl/pavs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page aging victim selector: shared package
// Field widths, operation codes and the control/status bundles that pass
// between the sequencer and the frame table datapath.
// ----------------------------------------------------------------------------
package pavs_pkg;

  localparam int FRAME_COUNT_DEF = 4096;
  localparam int OFFSET_BITS_DEF = 24;

  localparam int WORD_W      = 64;  // packed age + offset word
  localparam int OP_W        = 2;
  localparam int FIDX_W      = 12;
  localparam int PTE_W       = 24;
  localparam int AGE_FIELD_W = 40;

  typedef enum logic [OP_W-1:0] {
    OP_INSTALL = 2'd0,
    OP_REMOVE  = 2'd1,
    OP_AGE     = 2'd2,
    OP_FIND    = 2'd3
  } op_t;

  // Commands from the sequencer to the datapath
  typedef struct packed {
    logic load_req;     // capture the incoming request
    logic clr_wr;       // write an empty word at the sweep pointer
    logic ptr_rst;      // restart the sweep pointer, drop the running best
    logic scan_rd;      // read the frame at the sweep pointer for comparison
    logic wr_install;   // write a fresh word at the request frame
    logic wr_remove;    // empty the request frame
    logic res_miss;     // result: not found, echo index
    logic res_install;  // result: freshly installed frame
    logic age_wb;       // write back the aged word and form its result
    logic res_find;     // result: best frame of the scan
    logic out_load;     // move the result into the output register
  } pavs_cmd_t;

  // Status from the datapath to the sequencer
  typedef struct packed {
    op_t  req_op;
    logic in_range;
    logic ptr_last;
    logic out_free;
  } pavs_sts_t;

endpackage

@@ hdl/pavs_req_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page aging victim selector: request channel
// Valid/ready channel carrying one operation on the frame table.
// ----------------------------------------------------------------------------
interface pavs_req_if;
  import pavs_pkg::*;

  logic              valid;
  logic              ready;
  op_t               op;
  logic [FIDX_W-1:0] frame_index;
  logic [PTE_W-1:0]  pte_offset;
  logic              accessed;

  modport source (output valid, output op, output frame_index, output pte_offset,
                  output accessed, input ready);
  modport sink   (input valid, input op, input frame_index, input pte_offset,
                  input accessed, output ready);
endinterface

// ----------------------------------------------------------------------------
// Page aging victim selector: response channel
// Valid/ready channel carrying the result of one operation.
// ----------------------------------------------------------------------------
interface pavs_rsp_if;
  import pavs_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   found;
  logic [FIDX_W-1:0]      victim_frame;
  logic [PTE_W-1:0]       entry_offset;
  logic [AGE_FIELD_W-1:0] age_value;

  modport source (output valid, output found, output victim_frame,
                  output entry_offset, output age_value, input ready);
  modport sink   (input valid, input found, input victim_frame,
                  input entry_offset, input age_value, output ready);
endinterface

@@ hdl/pavs_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page aging victim selector: frame table datapath
// Single-port frame table with valid bit per word, sweep pointer, running
// minimum for the victim scan, result staging and the output register.
// ----------------------------------------------------------------------------
module pavs_dp #(
  parameter int FRAME_COUNT = pavs_pkg::FRAME_COUNT_DEF,
  parameter int OFFSET_BITS = pavs_pkg::OFFSET_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  pavs_pkg::pavs_cmd_t              cmd,
  output pavs_pkg::pavs_sts_t              sts,
  input  pavs_pkg::op_t                    in_op,
  input  logic [pavs_pkg::FIDX_W-1:0]      in_frame_index,
  input  logic [pavs_pkg::PTE_W-1:0]       in_pte_offset,
  input  logic                             in_accessed,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_found,
  output logic [pavs_pkg::FIDX_W-1:0]      out_victim_frame,
  output logic [pavs_pkg::PTE_W-1:0]       out_entry_offset,
  output logic [pavs_pkg::AGE_FIELD_W-1:0] out_age_value
);
  import pavs_pkg::*;

  localparam int IDX_W   = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
  localparam int AGE_W   = WORD_W - OFFSET_BITS;
  localparam int MEM_W   = WORD_W + 1;
  localparam int VLD_BIT = WORD_W;

  logic [MEM_W-1:0] mem [FRAME_COUNT];

  op_t                    req_op_r;
  logic [FIDX_W-1:0]      req_idx_r;
  logic [OFFSET_BITS-1:0] req_ofs_r;
  logic                   req_acc_r;

  logic [IDX_W-1:0]       ptr_r, ptr_nxt;
  logic                   cmp_en_r;
  logic [IDX_W-1:0]       cmp_idx_r;
  logic [MEM_W-1:0]       rdata_r;

  logic                   have_r;
  logic [AGE_W-1:0]       best_age_r;
  logic [IDX_W-1:0]       best_idx_r;
  logic [OFFSET_BITS-1:0] best_ofs_r;

  logic                   res_found_r, res_found_nxt;
  logic [FIDX_W-1:0]      res_frame_r, res_frame_nxt;
  logic [PTE_W-1:0]       res_ofs_r, res_ofs_nxt;
  logic [AGE_FIELD_W-1:0] res_age_r, res_age_nxt;

  logic                   out_valid_r;
  logic                   out_found_r;
  logic [FIDX_W-1:0]      out_frame_r;
  logic [PTE_W-1:0]       out_ofs_r;
  logic [AGE_FIELD_W-1:0] out_age_r;

  logic [IDX_W-1:0]       req_addr;
  logic [IDX_W-1:0]       mem_addr;
  logic                   mem_we;
  logic [MEM_W-1:0]       mem_wdata;
  logic                   rd_vld;
  logic [AGE_W-1:0]       rd_age;
  logic [OFFSET_BITS-1:0] rd_ofs;
  logic [AGE_W-1:0]       aged_age;
  logic                   better;
  logic                   ptr_last;

  assign req_addr = IDX_W'({{IDX_W{1'b0}}, req_idx_r});
  assign mem_addr = (cmd.clr_wr || cmd.scan_rd) ? ptr_r : req_addr;
  assign ptr_last = (ptr_r == IDX_W'(FRAME_COUNT - 1));

  assign rd_vld   = rdata_r[VLD_BIT];
  assign rd_age   = rdata_r[WORD_W-1:OFFSET_BITS];
  assign rd_ofs   = rdata_r[OFFSET_BITS-1:0];
  assign aged_age = {req_acc_r, rd_age[AGE_W-1:1]};

  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = '0;
    if (cmd.clr_wr || cmd.wr_remove) begin
      mem_we = 1'b1;
    end else if (cmd.wr_install) begin
      mem_we    = 1'b1;
      mem_wdata = {1'b1, {AGE_W{1'b1}}, req_ofs_r};
    end else if (cmd.age_wb && rd_vld) begin
      mem_we    = 1'b1;
      mem_wdata = {1'b1, aged_age, rd_ofs};
    end
  end

  // Read-first single port: data for the address of this cycle lands next cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rdata_r <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_op_r  <= in_op;
      req_idx_r <= in_frame_index;
      req_ofs_r <= OFFSET_BITS'({{OFFSET_BITS{1'b0}}, in_pte_offset});
      req_acc_r <= in_accessed;
    end
  end

  always_comb begin
    ptr_nxt = ptr_r;
    if (cmd.ptr_rst) begin
      ptr_nxt = '0;
    end else if (cmd.clr_wr || cmd.scan_rd) begin
      ptr_nxt = ptr_last ? '0 : ptr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r    <= '0;
      cmp_en_r <= 1'b0;
    end else begin
      ptr_r    <= ptr_nxt;
      cmp_en_r <= cmd.scan_rd;
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r <= ptr_r;
  end

  // Strict less-than keeps the lowest index on equal ages
  assign better = cmp_en_r && rd_vld && (!have_r || (rd_age < best_age_r));

  always_ff @(posedge clk) begin
    if (cmd.ptr_rst) begin
      have_r <= 1'b0;
    end else if (better) begin
      have_r     <= 1'b1;
      best_age_r <= rd_age;
      best_idx_r <= cmp_idx_r;
      best_ofs_r <= rd_ofs;
    end
  end

  always_comb begin
    res_found_nxt = res_found_r;
    res_frame_nxt = res_frame_r;
    res_ofs_nxt   = res_ofs_r;
    res_age_nxt   = res_age_r;
    if (cmd.res_miss || (cmd.age_wb && !rd_vld)) begin
      res_found_nxt = 1'b0;
      res_frame_nxt = req_idx_r;
      res_ofs_nxt   = '0;
      res_age_nxt   = '0;
    end else if (cmd.res_install) begin
      res_found_nxt = 1'b1;
      res_frame_nxt = req_idx_r;
      res_ofs_nxt   = PTE_W'({{PTE_W{1'b0}}, req_ofs_r});
      res_age_nxt   = AGE_FIELD_W'({{AGE_FIELD_W{1'b0}}, {AGE_W{1'b1}}});
    end else if (cmd.age_wb) begin
      res_found_nxt = 1'b1;
      res_frame_nxt = req_idx_r;
      res_ofs_nxt   = PTE_W'({{PTE_W{1'b0}}, rd_ofs});
      res_age_nxt   = AGE_FIELD_W'({{AGE_FIELD_W{1'b0}}, aged_age});
    end else if (cmd.res_find) begin
      res_found_nxt = have_r;
      res_frame_nxt = have_r ? FIDX_W'({{FIDX_W{1'b0}}, best_idx_r}) : '0;
      res_ofs_nxt   = have_r ? PTE_W'({{PTE_W{1'b0}}, best_ofs_r}) : '0;
      res_age_nxt   = have_r ? AGE_FIELD_W'({{AGE_FIELD_W{1'b0}}, best_age_r}) : '0;
    end
  end

  always_ff @(posedge clk) begin
    res_found_r <= res_found_nxt;
    res_frame_r <= res_frame_nxt;
    res_ofs_r   <= res_ofs_nxt;
    res_age_r   <= res_age_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_found_r <= res_found_r;
      out_frame_r <= res_frame_r;
      out_ofs_r   <= res_ofs_r;
      out_age_r   <= res_age_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_found        = out_found_r;
  assign out_victim_frame = out_frame_r;
  assign out_entry_offset = out_ofs_r;
  assign out_age_value    = out_age_r;

  assign sts.req_op   = req_op_r;
  assign sts.in_range = (32'(req_idx_r) < 32'(FRAME_COUNT));
  assign sts.ptr_last = ptr_last;
  assign sts.out_free = !out_valid_r || out_ready;

endmodule

@@ hdl/pavs_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page aging victim selector: sequencer
// One-hot state machine that clears the table after reset, decodes each
// request and steps the datapath through its read-modify-write or scan.
// ----------------------------------------------------------------------------
module pavs_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  pavs_pkg::pavs_sts_t sts,
  output pavs_pkg::pavs_cmd_t cmd
);
  import pavs_pkg::*;

  typedef enum logic [7:0] {
    ST_CLEAR    = 8'b0000_0001,
    ST_IDLE     = 8'b0000_0010,
    ST_DECODE   = 8'b0000_0100,
    ST_AGE_WB   = 8'b0000_1000,
    ST_SCAN     = 8'b0001_0000,
    ST_SCAN_END = 8'b0010_0000,
    ST_FIND_RES = 8'b0100_0000,
    ST_DONE     = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.ptr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_nxt    = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (sts.req_op == OP_FIND) begin
          cmd.ptr_rst = 1'b1;
          state_nxt   = ST_SCAN;
        end else if (!sts.in_range) begin
          cmd.res_miss = 1'b1;
          state_nxt    = ST_DONE;
        end else begin
          case (sts.req_op)
            OP_INSTALL: begin
              cmd.wr_install  = 1'b1;
              cmd.res_install = 1'b1;
              state_nxt       = ST_DONE;
            end
            OP_REMOVE: begin
              cmd.wr_remove = 1'b1;
              cmd.res_miss  = 1'b1;
              state_nxt     = ST_DONE;
            end
            default: begin
              state_nxt = ST_AGE_WB;
            end
          endcase
        end
      end
      ST_AGE_WB: begin
        cmd.age_wb = 1'b1;
        state_nxt  = ST_DONE;
      end
      ST_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (sts.ptr_last) begin
          state_nxt = ST_SCAN_END;
        end
      end
      ST_SCAN_END: begin
        state_nxt = ST_FIND_RES;
      end
      ST_FIND_RES: begin
        cmd.res_find = 1'b1;
        state_nxt    = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == ST_IDLE);

endmodule

@@ hdl/page_aging_victim_selector_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page aging victim selector
// Per-frame age/offset table with install, remove, age and victim search.
// ----------------------------------------------------------------------------
// Usage:
//   in_req  : one request per valid/ready handshake (op, frame_index,
//             pte_offset, accessed).
//   out_rsp : one response per request, in request order (found,
//             victim_frame, entry_offset, age_value).
// Steps from the accepting edge to the edge that raises out_rsp.valid:
//   install, remove, out-of-range index : decode, load output
//   age                                 : read, write back, load output
//   find victim                         : decode, scan of every frame,
//                                         scan end, find result, load
//                                         output; the table has one port,
//                                         so the scan reads one frame per cycle.
// Requests are handled one at a time; the next is taken once the sequencer
// is back in idle after the previous response is loaded into the output
// register.
// Reset: a clearing pass writes every frame empty, with in_req.ready low
// throughout.
// Stall: a held response keeps its value; the following request is still
// accepted and processed, and waits for the output register to free up.
// ----------------------------------------------------------------------------
module page_aging_victim_selector_core #(
  parameter int FRAME_COUNT = pavs_pkg::FRAME_COUNT_DEF,
  parameter int OFFSET_BITS = pavs_pkg::OFFSET_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  pavs_req_if.sink   in_req,
  pavs_rsp_if.source out_rsp
);
  import pavs_pkg::*;

  pavs_cmd_t cmd;    // sequencer -> datapath
  pavs_sts_t sts;    // datapath -> sequencer
  logic      ctrl_in_ready;

  // Sequencer: clearing pass, request decode and scan stepping
  pavs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (ctrl_in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: frame table, running minimum and output register
  pavs_dp #(
    .FRAME_COUNT (FRAME_COUNT),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_op            (in_req.op),
    .in_frame_index   (in_req.frame_index),
    .in_pte_offset    (in_req.pte_offset),
    .in_accessed      (in_req.accessed),
    .out_valid        (out_rsp.valid),
    .out_ready        (out_rsp.ready),
    .out_found        (out_rsp.found),
    .out_victim_frame (out_rsp.victim_frame),
    .out_entry_offset (out_rsp.entry_offset),
    .out_age_value    (out_rsp.age_value)
  );

  // Request ready only while the sequencer sits idle
  assign in_req.ready = ctrl_in_ready;

endmodule

@@ hdl/pavs_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page aging victim selector: port checker
// Watches the request and response ports over time; bound to the core.
// ----------------------------------------------------------------------------
module pavs_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic                             out_found,
  input logic [pavs_pkg::FIDX_W-1:0]      out_victim_frame,
  input logic [pavs_pkg::PTE_W-1:0]       out_entry_offset,
  input logic [pavs_pkg::AGE_FIELD_W-1:0] out_age_value
);
  import pavs_pkg::*;

  // Held response keeps valid and every field
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_found) &&
      $stable(out_victim_frame) && $stable(out_entry_offset) && $stable(out_age_value))
    else $error("response changed while stalled");

  // Reset leaves no response pending and starts the clearing pass
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_ready)
    else $error("ports active right after reset");

  // A miss reports an empty entry
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_entry_offset == '0 && out_age_value == '0)
    else $error("miss with nonzero offset or age");

  // One request in flight: ready drops right after acceptance
  a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while another in flight");

endmodule

bind page_aging_victim_selector_core pavs_checker u_pavs_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_req.valid),
  .in_ready         (in_req.ready),
  .out_valid        (out_rsp.valid),
  .out_ready        (out_rsp.ready),
  .out_found        (out_rsp.found),
  .out_victim_frame (out_rsp.victim_frame),
  .out_entry_offset (out_rsp.entry_offset),
  .out_age_value    (out_rsp.age_value)
);
